/* sv/cst_pkg.sv */
// Shared types and constants for the constant strain triangle stiffness block.
package cst_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W  = 32;
   localparam int NODE_W   = 12;
   localparam int DOF_W    = NODE_W + 1;
   localparam int VAL_W    = 64;
   localparam int SCALE_W  = 48;
   localparam int POIS_W   = 15;

   // Internal arithmetic widths.
   localparam int DIFF_W   = COORD_W + 1;      // coordinate difference
   localparam int DPROD_W  = 2 * DIFF_W;       // product of two differences
   localparam int ABSD_W   = DPROD_W;          // magnitude of the doubled area
   localparam int MAG_W    = 65;               // product of two difference magnitudes
   localparam int COEF_W   = 18;               // bracket coefficient
   localparam int TERM_W   = 83;               // magnitude product times coefficient
   localparam int BRK_W    = 85;               // signed bracket
   localparam int PMAG_W   = 84;               // bracket magnitude
   localparam int PCH_W    = 28;               // bracket chunk for the scale multiply
   localparam int SCH_W    = 24;               // scale chunk for the scale multiply
   localparam int PP_W     = PCH_W + SCH_W;
   localparam int ROW_W    = PCH_W + SCALE_W;
   localparam int PROD_W   = PMAG_W + SCALE_W;
   localparam int NUM_W    = 117;              // rounded numerator over 2^17
   localparam int QUO_W    = VAL_W;
   localparam int CMP_W    = ABSD_W + QUO_W;

   // Defaults and codes.
   localparam int                  MAX_NODES_DEF = 4096;
   localparam logic [POIS_W-1:0]   POIS_RESET    = 15'd19661;
   localparam logic [COEF_W-1:0]   COEF_DIAG     = 18'd131072;
   localparam logic [COEF_W-1:0]   COEF_HALF     = 18'd65536;
   localparam logic [2:0]          LAST_IDX      = 3'd5;

   localparam int                  CSR_IDX_W     = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POISSON  = 1'b1;

   // Input item.
   typedef struct packed {
      logic signed [COORD_W-1:0] x_first;
      logic signed [COORD_W-1:0] y_first;
      logic signed [COORD_W-1:0] x_second;
      logic signed [COORD_W-1:0] y_second;
      logic signed [COORD_W-1:0] x_third;
      logic signed [COORD_W-1:0] y_third;
      logic [NODE_W-1:0]         node_first;
      logic [NODE_W-1:0]         node_second;
      logic [NODE_W-1:0]         node_third;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [DOF_W-1:0]        row_dof;
      logic [DOF_W-1:0]        col_dof;
      logic signed [VAL_W-1:0] entry_value;
      logic                    degenerate;
      logic                    last_entry;
   } rsp_type;

   // Per-triangle values held while its entries are issued.
   typedef struct packed {
      logic [2:0][DIFF_W-1:0] bb;
      logic [2:0][DIFF_W-1:0] cc;
      logic [2:0][NODE_W-1:0] node;
      logic [ABSD_W-1:0]      absd;
      logic                   degen;
   } tri_type;

   // Tags that travel with each entry down the pipeline.
   typedef struct packed {
      logic [DOF_W-1:0]  row_dof;
      logic [DOF_W-1:0]  col_dof;
      logic              degen;
      logic              last;
      logic              neg;
      logic [ABSD_W-1:0] absd;
   } meta_type;

   // Operands of one entry.
   typedef struct packed {
      logic [DIFF_W-1:0] f1a;
      logic [DIFF_W-1:0] f1b;
      logic [DIFF_W-1:0] f2a;
      logic [DIFF_W-1:0] f2b;
      logic [COEF_W-1:0] coef1;
      logic [COEF_W-1:0] coef2;
      meta_type          meta;
   } issue_type;

endpackage

/* sv/cst_element_stiffness.sv */
// Top level: configuration registers, entry sequencer and the numerator and divider pipelines.
// A new triangle is accepted only while busy is low; busy falls when its last entry is issued.
// After the setup stages, its 36 entries are issued one a cycle, row by row.
// Entries of a triangle leave back to back, through the bracket pipeline and then the divider.
// Results cannot be held off, so the pipeline never stalls.
// Synchronous reset clears all valid bits and the sequencer and restores both registers.
module cst_element_stiffness #(
   parameter int MAX_NODES = cst_pkg::MAX_NODES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  cst_pkg::req_type                req_data,
   input  logic                            csr_we,
   input  logic [cst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cst_pkg::SCALE_W-1:0]     csr_wdata,
   output logic                            rsp_valid,
   output cst_pkg::rsp_type                rsp_data
);
   import cst_pkg::*;

   logic [SCALE_W-1:0] scale_ff;
   logic [POIS_W-1:0]  pois_ff;
   logic               busy_ff, act_ff, ivld_ff, accept, last_issue;
   logic [2:0]         row_ff, col_ff;
   logic               tri_valid, br_valid;
   tri_type            tri_q;
   issue_type          issue_ff, issue_in;
   logic [1:0]         nr, ns;
   logic               ar, ac;
   logic [NUM_W-1:0]   br_num;
   meta_type           br_meta;

   assign accept     = start && !busy_ff;
   assign last_issue = act_ff && (row_ff == LAST_IDX) && (col_ff == LAST_IDX);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         pois_ff  <= POIS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE:   scale_ff <= csr_wdata;
            CSR_POISSON: pois_ff  <= csr_wdata[POIS_W-1:0];
            default: ;
         endcase
      end
   end

   cst_setup #(.MAX_NODES(MAX_NODES)) u_setup (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .req       (req_data),
      .tri_valid (tri_valid),
      .tri_out   (tri_q)
   );

   // Operand selection for the current row and column.
   always_comb begin
      nr = row_ff[2:1];
      ar = row_ff[0];
      ns = col_ff[2:1];
      ac = col_ff[0];
      issue_in.f1a   = ar ? tri_q.cc[nr] : tri_q.bb[nr];
      issue_in.f1b   = ac ? tri_q.cc[ns] : tri_q.bb[ns];
      issue_in.f2a   = ar ? tri_q.bb[nr] : tri_q.cc[nr];
      issue_in.f2b   = ac ? tri_q.bb[ns] : tri_q.cc[ns];
      issue_in.coef1 = (ar == ac) ? COEF_DIAG : {2'b00, pois_ff, 1'b0};
      issue_in.coef2 = COEF_HALF - COEF_W'(pois_ff);
      issue_in.meta.row_dof = {tri_q.node[nr], ar};
      issue_in.meta.col_dof = {tri_q.node[ns], ac};
      issue_in.meta.degen   = tri_q.degen;
      issue_in.meta.last    = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);
      issue_in.meta.neg     = 1'b0;
      issue_in.meta.absd    = tri_q.absd;
   end

   // Sequencer: walks the 36 entries row by row.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         act_ff  <= 1'b0;
         ivld_ff <= 1'b0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         ivld_ff <= act_ff;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (last_issue) begin
            busy_ff <= 1'b0;
         end
         if (tri_valid) begin
            act_ff <= 1'b1;
            row_ff <= '0;
            col_ff <= '0;
         end else if (act_ff) begin
            if (col_ff == LAST_IDX) begin
               col_ff <= '0;
               if (row_ff == LAST_IDX) begin
                  act_ff <= 1'b0;
                  row_ff <= '0;
               end else begin
                  row_ff <= row_ff + 3'd1;
               end
            end else begin
               col_ff <= col_ff + 3'd1;
            end
         end
      end
      issue_ff <= issue_in;
   end

   cst_bracket u_bracket (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ivld_ff),
      .issue     (issue_ff),
      .scale     (scale_ff),
      .out_valid (br_valid),
      .num       (br_num),
      .meta      (br_meta)
   );

   cst_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (br_valid),
      .num       (br_num),
      .meta      (br_meta),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   assign busy = busy_ff;

endmodule

/* sv/cst_setup.sv */
// Triangle setup: edge coefficients, doubled area and clamped node indices.
module cst_setup #(
   parameter int MAX_NODES = cst_pkg::MAX_NODES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cst_pkg::req_type req,
   output logic             tri_valid,
   output cst_pkg::tri_type tri_out
);
   import cst_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff;
   logic [2:0][DIFF_W-1:0]    bb1_ff, bb2_ff, bb3_ff, bb_in;
   logic [2:0][DIFF_W-1:0]    cc1_ff, cc2_ff, cc3_ff, cc_in;
   logic [2:0][NODE_W-1:0]    nd1_ff, nd2_ff, nd3_ff, nd_in;
   logic signed [DIFF_W-1:0]  dx1_ff, dy2_ff, dx2_ff, dy1_ff;
   logic signed [DIFF_W-1:0]  dx1_in, dy2_in, dx2_in, dy1_in;
   logic signed [DPROD_W-1:0] pa_ff, pb_ff;
   logic signed [DPROD_W:0]   det;
   logic [ABSD_W-1:0]         absd_ff, absd_in;
   logic                      degen_ff;

   function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = n;
      if (32'(n) >= MAX_NODES) r = NODE_W'(MAX_NODES - 1);
      return r;
   endfunction

   function automatic logic [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                               input logic signed [COORD_W-1:0] b);
      logic signed [DIFF_W-1:0] r;
      r = DIFF_W'(a) - DIFF_W'(b);
      return r;
   endfunction

   // First stage: coordinate differences.
   always_comb begin
      bb_in[0] = sdiff(req.y_second, req.y_third);
      bb_in[1] = sdiff(req.y_third,  req.y_first);
      bb_in[2] = sdiff(req.y_first,  req.y_second);
      cc_in[0] = sdiff(req.x_third,  req.x_second);
      cc_in[1] = sdiff(req.x_first,  req.x_third);
      cc_in[2] = sdiff(req.x_second, req.x_first);
      dx1_in   = sdiff(req.x_second, req.x_first);
      dy2_in   = sdiff(req.y_third,  req.y_first);
      dx2_in   = sdiff(req.x_third,  req.x_first);
      dy1_in   = sdiff(req.y_second, req.y_first);
      nd_in[0] = clamp_node(req.node_first);
      nd_in[1] = clamp_node(req.node_second);
      nd_in[2] = clamp_node(req.node_third);
   end

   // Third stage: doubled signed area and its magnitude.
   always_comb begin
      det     = (DPROD_W + 1)'(pa_ff) - (DPROD_W + 1)'(pb_ff);
      absd_in = det[DPROD_W] ? ABSD_W'(-det) : ABSD_W'(det);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= load;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (load) begin
         bb1_ff <= bb_in;
         cc1_ff <= cc_in;
         nd1_ff <= nd_in;
         dx1_ff <= dx1_in;
         dy2_ff <= dy2_in;
         dx2_ff <= dx2_in;
         dy1_ff <= dy1_in;
      end
      if (v1_ff) begin
         bb2_ff <= bb1_ff;
         cc2_ff <= cc1_ff;
         nd2_ff <= nd1_ff;
         pa_ff  <= dx1_ff * dy2_ff;
         pb_ff  <= dx2_ff * dy1_ff;
      end
      if (v2_ff) begin
         bb3_ff   <= bb2_ff;
         cc3_ff   <= cc2_ff;
         nd3_ff   <= nd2_ff;
         absd_ff  <= absd_in;
         degen_ff <= (det == '0);
      end
   end

   assign tri_valid     = v3_ff;
   assign tri_out.bb    = bb3_ff;
   assign tri_out.cc    = cc3_ff;
   assign tri_out.node  = nd3_ff;
   assign tri_out.absd  = absd_ff;
   assign tri_out.degen = degen_ff;

endmodule

/* sv/cst_bracket.sv */
// Entry numerator pipeline: bracket products, scale multiply and rounding offset.
module cst_bracket (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  cst_pkg::issue_type           issue,
   input  logic [cst_pkg::SCALE_W-1:0]  scale,
   output logic                         out_valid,
   output logic [cst_pkg::NUM_W-1:0]    num,
   output cst_pkg::meta_type            meta
);
   import cst_pkg::*;

   localparam int NSTG     = 9;
   localparam int SIGN_STG = 4;

   logic [NSTG-1:0]           vld_ff;
   meta_type [NSTG-1:0]       meta_ff;
   meta_type                  meta_sign_in;
   logic [2:0]                s1_ff, s2_ff;
   logic [MAG_W-1:0]          m1_ff, m2_ff;
   logic [COEF_W-1:0]         k1_ff, k2_ff;
   logic [PP_W-1:0]           l1_ff, l2_ff;
   logic [PP_W:0]             h1_ff, h2_ff;
   logic [TERM_W-1:0]         t1_ff, t2_ff;
   logic [BRK_W-1:0]          p_ff, e1, e2;
   logic [PMAG_W-1:0]         pabs_ff;
   logic [2:0][1:0][PP_W-1:0] pp_ff;
   logic [2:0][ROW_W-1:0]     row_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [PROD_W+1:0]         nsum;
   logic [NUM_W-1:0]          num_ff;

   function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] a);
      return a[DIFF_W-1] ? DIFF_W'(-a) : a;
   endfunction

   // Signed bracket from the two terms, and the rounding offset numerator.
   always_comb begin
      e1   = BRK_W'(t1_ff);
      e2   = BRK_W'(t2_ff);
      nsum = ((PROD_W + 2)'(prod_ff) << 1) + ((PROD_W + 2)'(meta_ff[7].absd) << 16);
      // Sign of the bracket joins the tags once it is known.
      meta_sign_in     = meta_ff[SIGN_STG-1];
      meta_sign_in.neg = p_ff[BRK_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
      meta_ff[0] <= issue.meta;
      for (int i = 1; i < NSTG; i++) begin
         if (i != SIGN_STG) meta_ff[i] <= meta_ff[i-1];
      end
      meta_ff[SIGN_STG] <= meta_sign_in;
      // Magnitude products of the coefficient pairs; the signs follow them to the bracket.
      m1_ff <= MAG_W'(mag(issue.f1a) * mag(issue.f1b));
      m2_ff <= MAG_W'(mag(issue.f2a) * mag(issue.f2b));
      s1_ff <= {s1_ff[1:0], issue.f1a[DIFF_W-1] ^ issue.f1b[DIFF_W-1]};
      s2_ff <= {s2_ff[1:0], issue.f2a[DIFF_W-1] ^ issue.f2b[DIFF_W-1]};
      k1_ff <= issue.coef1;
      k2_ff <= issue.coef2;
      // Coefficient multiply in two halves.
      l1_ff <= PP_W'(m1_ff[31:0] * k1_ff);
      h1_ff <= (PP_W + 1)'(m1_ff[MAG_W-1:32] * k1_ff);
      l2_ff <= PP_W'(m2_ff[31:0] * k2_ff);
      h2_ff <= (PP_W + 1)'(m2_ff[MAG_W-1:32] * k2_ff);
      t1_ff <= TERM_W'(l1_ff) + (TERM_W'(h1_ff) << 32);
      t2_ff <= TERM_W'(l2_ff) + (TERM_W'(h2_ff) << 32);
      // Signed bracket, then its magnitude.
      p_ff    <= (s1_ff[2] ? -e1 : e1) + (s2_ff[2] ? -e2 : e2);
      pabs_ff <= p_ff[BRK_W-1] ? PMAG_W'(-p_ff) : PMAG_W'(p_ff);
      // Scale multiply as six partial products.
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 2; j++) begin
            pp_ff[i][j] <= pabs_ff[PCH_W*i +: PCH_W] * scale[SCH_W*j +: SCH_W];
         end
      end
      for (int i = 0; i < 3; i++) begin
         row_ff[i] <= ROW_W'(pp_ff[i][0]) + (ROW_W'(pp_ff[i][1]) << SCH_W);
      end
      prod_ff <= PROD_W'(row_ff[0]) + (PROD_W'(row_ff[1]) << PCH_W)
               + (PROD_W'(row_ff[2]) << (2 * PCH_W));
      num_ff  <= nsum[PROD_W+1:17];
   end

   assign out_valid = vld_ff[NSTG-1];
   assign num       = num_ff;
   assign meta      = meta_ff[NSTG-1];

endmodule

/* sv/cst_divider.sv */
// Pipelined restoring divider with saturation, one quotient bit per stage.
module cst_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [cst_pkg::NUM_W-1:0] num,
   input  cst_pkg::meta_type         meta,
   output logic                      rsp_valid,
   output cst_pkg::rsp_type          rsp
);
   import cst_pkg::*;

   localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] NEG_MAG = {1'b1, {(VAL_W-1){1'b0}}};

   logic [QUO_W:0]              vld_ff;
   logic [QUO_W:0]              ovf_ff;
   logic [QUO_W:0][NUM_W-1:0]   rem_ff;
   logic [QUO_W:0][QUO_W-1:0]   quo_ff;
   meta_type [QUO_W:0]          meta_ff;
   logic [QUO_W-1:0][CMP_W-1:0] dsh, rx;
   logic [QUO_W-1:0]            ge;
   logic [QUO_W-1:0][NUM_W-1:0] rem_in;
   logic [QUO_W-1:0][QUO_W-1:0] quo_in;
   logic [QUO_W-1:0]            q;
   logic [VAL_W-1:0]            mres;
   logic                        out_vld_ff;
   rsp_type                     rsp_ff, rsp_in;

   // One quotient bit per stage, most significant first.
   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         dsh[k]    = CMP_W'(meta_ff[k].absd) << (QUO_W - 1 - k);
         rx[k]     = CMP_W'(rem_ff[k]);
         ge[k]     = (rx[k] >= dsh[k]);
         rem_in[k] = ge[k] ? NUM_W'(rx[k] - dsh[k]) : rem_ff[k];
         quo_in[k] = quo_ff[k] | (ge[k] ? (QUO_W'(1) << (QUO_W - 1 - k)) : '0);
      end
   end

   // Entry stage checks for overflow against the divisor shifted by the quotient width.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QUO_W-1:0], in_valid};
      end
      ovf_ff[0]  <= (ABSD_W'(num[NUM_W-1:QUO_W]) >= meta.absd);
      rem_ff[0]  <= num;
      quo_ff[0]  <= '0;
      meta_ff[0] <= meta;
      for (int k = 0; k < QUO_W; k++) begin
         rem_ff[k+1]  <= rem_in[k];
         quo_ff[k+1]  <= quo_in[k];
         ovf_ff[k+1]  <= ovf_ff[k];
         meta_ff[k+1] <= meta_ff[k];
      end
   end

   // Saturation, sign and degenerate override.
   always_comb begin
      q = quo_ff[QUO_W];
      if (meta_ff[QUO_W].neg) begin
         mres = (ovf_ff[QUO_W] || q > NEG_MAG) ? NEG_MAG : q;
         mres = -mres;
      end else begin
         mres = (ovf_ff[QUO_W] || q[QUO_W-1]) ? POS_MAX : q;
      end
      rsp_in.row_dof     = meta_ff[QUO_W].row_dof;
      rsp_in.col_dof     = meta_ff[QUO_W].col_dof;
      rsp_in.entry_value = meta_ff[QUO_W].degen ? '0 : mres;
      rsp_in.degenerate  = meta_ff[QUO_W].degen;
      rsp_in.last_entry  = meta_ff[QUO_W].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QUO_W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = rsp_ff;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the constant strain triangle element stiffness block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cst_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 120;
   localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
   localparam logic [POIS_W-1:0]  POIS_MAX  = {POIS_W{1'b1}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] ONE   = 32'sh0001_0000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SCALE_W-1:0] csr_wdata;
   logic rsp_valid;
   rsp_type rsp_data;

   cst_element_stiffness i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Local copy of the configuration registers.
   logic [SCALE_W-1:0] model_scale;
   logic [POIS_W-1:0]  model_poisson;

   rsp_type pending_entries[$];
   int fail_count;
   int idle_cycles;

   // Directed stimulus: either a register write or a triangle, with optional typed value.
   typedef struct {
      bit                      is_csr;
      logic [CSR_IDX_W-1:0]    idx;
      logic [SCALE_W-1:0]      wdata;
      req_type                 tri_in;
      bit                      typed;
      logic signed [VAL_W-1:0] tval;
      bit                      tdegen;
   } step_type;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Works out the 36 entries of one triangle and queues them.
   function automatic void predict_stiffness(req_type t, bit typed,
                                             logic signed [VAL_W-1:0] tval, bit tdegen);
      logic signed [255:0] xs[3];
      logic signed [255:0] ys[3];
      logic signed [255:0] bb[3];
      logic signed [255:0] cc[3];
      logic [NODE_W-1:0] nodes[3];
      logic signed [255:0] dd, t1, t2, pv, c1, c2;
      logic [255:0] den, num, quo, pmag;
      logic neg, degen;
      int r, c, nr, ar, ns, as_;
      rsp_type e;
      xs[0] = t.x_first;  ys[0] = t.y_first;
      xs[1] = t.x_second; ys[1] = t.y_second;
      xs[2] = t.x_third;  ys[2] = t.y_third;
      nodes[0] = t.node_first; nodes[1] = t.node_second; nodes[2] = t.node_third;
      for (int i = 0; i < 3; i++) begin
         bb[i] = ys[(i+1)%3] - ys[(i+2)%3];
         cc[i] = xs[(i+2)%3] - xs[(i+1)%3];
      end
      dd = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (xs[2] - xs[0]) * (ys[1] - ys[0]);
      degen = (dd == 0);
      den = (dd < 0) ? -dd : dd;
      den = den << 16;
      for (int p = 0; p < 36; p++) begin
         r = p / 6; c = p % 6;
         nr = r >> 1; ar = r & 1; ns = c >> 1; as_ = c & 1;
         e.row_dof = {nodes[nr], ar[0]};
         e.col_dof = {nodes[ns], as_[0]};
         e.degenerate = degen;
         e.last_entry = (p == 35);
         e.entry_value = '0;
         if (!degen) begin
            c1 = (ar == as_) ? 256'sd131072 : 256'(2 * model_poisson);
            c2 = 256'(65536 - model_poisson);
            t1 = (ar ? cc[nr] : bb[nr]) * (as_ ? cc[ns] : bb[ns]) * c1;
            t2 = (ar ? bb[nr] : cc[nr]) * (as_ ? bb[ns] : cc[ns]) * c2;
            pv = t1 + t2;
            neg = pv < 0;
            pmag = neg ? -pv : pv;
            // Round half away from zero on the magnitude.
            num = ((pmag * 256'(model_scale)) << 1) + den;
            quo = num / (den << 1);
            if (neg)
               e.entry_value = (quo > 256'h8000_0000_0000_0000) ? VAL_MIN : -quo[63:0];
            else
               e.entry_value = (quo > 256'h7FFF_FFFF_FFFF_FFFF) ? VAL_MAX : quo[63:0];
         end
         if (typed) begin
            e.entry_value = tval;
            e.degenerate = tdegen;
         end
         pending_entries = {pending_entries, e};
      end
   endfunction

   // One register write; only called while the block is idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SCALE_W-1:0] value);
      start <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SCALE) model_scale = value;
      else model_poisson = value[POIS_W-1:0];
   endtask

   // Offers one triangle, waits for the transfer, then idles a random spell.
   task automatic send_triangle(req_type t, bit typed, logic signed [VAL_W-1:0] tval,
                                bit tdegen);
      int gap;
      req_data <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_stiffness(t, typed, tval, tdegen);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type make_tri(logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2,
                                        logic [NODE_W-1:0] n0, n1, n2);
      make_tri = '{x0, y0, x1, y1, x2, y2, n0, n1, n2};
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
      if (mode == 0) rand_coord = $urandom_range(0, 32'h0040_0000) - 32'sh0020_0000;
      else rand_coord = $urandom;
   endfunction

   // Random triangle: mostly moderate sizes, some full range, a few degenerate.
   function automatic req_type rand_tri();
      req_type t;
      int mode;
      mode = $urandom_range(0, 9);
      t.x_first  = rand_coord(mode < 6 ? 0 : 1);
      t.y_first  = rand_coord(mode < 6 ? 0 : 1);
      t.x_second = rand_coord(mode < 6 ? 0 : 1);
      t.y_second = rand_coord(mode < 6 ? 0 : 1);
      t.x_third  = rand_coord(mode < 6 ? 0 : 1);
      t.y_third  = rand_coord(mode < 6 ? 0 : 1);
      if (mode == 9) begin
         t.x_third = t.x_second;
         t.y_third = t.y_second;
      end
      t.node_first  = $urandom;
      t.node_second = $urandom;
      t.node_third  = $urandom;
      return t;
   endfunction

   // Result checking and the idle watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("cst_element_stiffness: mismatch");
            $finish;
         end
         if (rsp_valid) begin
            if (pending_entries.size() == 0) begin
               $error("unexpected entry transfer");
               fail_count++;
            end else begin
               want = pending_entries.pop_front();
               if (rsp_data.row_dof !== want.row_dof) begin
                  $error("row_dof: expected %0d, got %0d", want.row_dof, rsp_data.row_dof);
                  fail_count++;
               end
               if (rsp_data.col_dof !== want.col_dof) begin
                  $error("col_dof: expected %0d, got %0d", want.col_dof, rsp_data.col_dof);
                  fail_count++;
               end
               if (rsp_data.entry_value !== want.entry_value) begin
                  $error("entry_value: expected %0d, got %0d", want.entry_value,
                         rsp_data.entry_value);
                  fail_count++;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0b, got %0b", want.degenerate,
                         rsp_data.degenerate);
                  fail_count++;
               end
               if (rsp_data.last_entry !== want.last_entry) begin
                  $error("last_entry: expected %0b, got %0b", want.last_entry,
                         rsp_data.last_entry);
                  fail_count++;
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      step_type steps[$];
      step_type s;
      req_type right;
      model_scale = '0;
      model_poisson = POIS_RESET;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_SCALE;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      right = make_tri(0, 0, ONE, 0, 0, ONE, 0, 1, 2);
      // Scale is zero after reset, so every value is zero.
      s = '{0, CSR_SCALE, 0, right, 1, 0, 0};                     steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(0, 0, 0, 0, 0, 0, 4095, 0, 4095), 1, 0, 1};
      steps = {steps, s};
      s = '{1, CSR_SCALE, 48'd1_000_000_000, '0, 0, 0, 0};          steps = {steps, s};
      s = '{0, CSR_SCALE, 0, right, 0, 0, 0};                     steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(ONE, ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 7, 8, 9), 1, 0, 1};
      steps = {steps, s};
      s = '{1, CSR_POISSON, {33'h1_5555_aaaa, POIS_MAX}, '0, 0, 0, 0}; steps = {steps, s};
      s = '{1, CSR_SCALE, SCALE_MAX, '0, 0, 0, 0};                 steps = {steps, s};
      s = '{0, CSR_SCALE, 0, right, 0, 0, 0};                     steps = {steps, s};
      // Full-range corners, then a thin sliver with huge scale whose entries saturate.
      s = '{0, CSR_SCALE, 0, make_tri(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 4095, 4095, 0),
            0, 0, 0};
      steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(0, 0, 1, 0, C_MAX, C_MIN, 100, 200, 300), 0, 0, 0};
      steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 1, 2, 3), 1, 0, 1};
      steps = {steps, s};
      s = '{1, CSR_POISSON, 0, '0, 0, 0, 0};                       steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(0, 0, ONE, 0, 0, ONE, 4095, 2048, 1), 0, 0, 0};
      steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(C_MIN, 0, C_MAX, 0, 0, C_MAX, 5, 6, 7), 0, 0, 0};
      steps = {steps, s};
      s = '{1, CSR_POISSON, POIS_RESET, '0, 0, 0, 0};              steps = {steps, s};
      s = '{1, CSR_SCALE, 48'd12345, '0, 0, 0, 0};                 steps = {steps, s};
      s = '{0, CSR_SCALE, 0, make_tri(0, 0, 3, 0, 0, 5, 10, 11, 12), 0, 0, 0};
      steps = {steps, s};

      foreach (steps[i]) begin
         if (steps[i].is_csr) write_reg(steps[i].idx, steps[i].wdata);
         else send_triangle(steps[i].tri_in, steps[i].typed, steps[i].tval, steps[i].tdegen);
      end

      // Random phases with a fresh setting of both registers each time.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) begin
            start <= 1'b0;
            case ($urandom_range(0, 3))
               0: write_reg(CSR_SCALE, SCALE_MAX);
               1: write_reg(CSR_SCALE, '0);
               2: write_reg(CSR_SCALE, SCALE_W'($urandom_range(1, 32'h7fff_ffff)));
               default: write_reg(CSR_SCALE, SCALE_W'({$urandom, $urandom}));
            endcase
            case ($urandom_range(0, 2))
               0: write_reg(CSR_POISSON, '0);
               1: write_reg(CSR_POISSON, SCALE_W'({$urandom, POIS_MAX}));
               default: write_reg(CSR_POISSON, SCALE_W'({$urandom, $urandom}));
            endcase
         end
         send_triangle(rand_tri(), 0, 0, 0);
      end
      start <= 1'b0;

      while (pending_entries.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("cst_element_stiffness: match");
      else
         $display("cst_element_stiffness: mismatch");
      $finish;
   end
endmodule
